[hdl/fwna_pkg.sv]
// Shared types and constants for the fixed-width number to ASCII block.
// Used by fwna_ctrl, fwna_datapath and the top level; depends on nothing.
`default_nettype none

package fwna_pkg;

  localparam int VALUE_W = 64;
  localparam int COUNT_W = 5;
  localparam int CHAR_W  = 7;
  localparam int BITCNT_W = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
  localparam logic [3:0]        DIGIT_TEN  = 4'd10;
  localparam logic [3:0]        DABBLE_MIN = 4'd5;
  localparam logic [3:0]        DABBLE_ADD = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hex_mode;
    logic zero_count;
    logic conv_done;
    logic last_digit;
  } ctrl_sts_t;

endpackage

`default_nettype wire

[hdl/fwna_ctrl.sv]
// Controller state machine: sequences load, binary-to-BCD conversion (decimal
// only) and character output. Depends on fwna_pkg.
`default_nettype none

module fwna_ctrl
  import fwna_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire ctrl_sts_t sts,
  output logic           busy,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (sts.zero_count) begin
            state_next = ST_IDLE;
          end else if (sts.hex_mode) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (sts.conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.last_digit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy      = 1'b1;
    cmd.load  = 1'b0;
    cmd.shift = 1'b0;
    cmd.emit  = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV: cmd.shift = 1'b1;
      ST_EMIT: cmd.emit  = 1'b1;
      default: busy      = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

[hdl/fwna_datapath.sv]
// Datapath: digit register, shift-add-3 BCD converter, counters and the
// character output register. Depends on fwna_pkg.
`default_nettype none

module fwna_datapath
  import fwna_pkg::*;
#(
  parameter int MAX_DIGITS = 20
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               func,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [COUNT_W-1:0] digit_count,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_sts_t               sts,
  output logic [CHAR_W-1:0]       ascii_char,
  output logic                    last,
  output logic                    char_valid
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_DIGITS);

  logic [BCD_W-1:0]    digits;
  logic [VALUE_W-1:0]  shreg;
  logic [BITCNT_W-1:0] bitcnt;
  logic [IDX_W-1:0]    idx;

  logic [COUNT_W-1:0]  count_clamped;
  logic [BCD_W-1:0]    hex_load;
  logic [BCD_W-1:0]    adjusted;
  logic [BCD_W-1:0]    sel_shifted;
  logic [3:0]          cur_digit;
  logic [CHAR_W-1:0]   cur_char;

  // Clamp the requested count
  assign count_clamped = (digit_count > MAX_COUNT) ? MAX_COUNT : digit_count;

  // Hex digits are the low nibbles of the value, zero above bit 63
  generate
    if (BCD_W <= VALUE_W) begin : g_hex_trunc
      assign hex_load = value[BCD_W-1:0];
    end else begin : g_hex_pad
      assign hex_load = {{(BCD_W - VALUE_W){1'b0}}, value};
    end
  endgenerate

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (digits[k*4 +: 4] >= DABBLE_MIN) begin
        adjusted[k*4 +: 4] = digits[k*4 +: 4] + DABBLE_ADD;
      end else begin
        adjusted[k*4 +: 4] = digits[k*4 +: 4];
      end
    end
  end

  // Current digit and its character
  assign sel_shifted = digits >> {idx, 2'b00};
  assign cur_digit   = sel_shifted[3:0];
  assign cur_char    = (cur_digit < DIGIT_TEN) ? (ASCII_ZERO + {3'b000, cur_digit})
                                               : (ASCII_A + {3'b000, cur_digit - DIGIT_TEN});

  // Status to the controller
  assign sts.hex_mode   = func;
  assign sts.zero_count = (digit_count == '0);
  assign sts.conv_done  = (bitcnt == BITCNT_W'(VALUE_W - 1));
  assign sts.last_digit = (idx == '0);

  // Digit register, shift register and counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx    <= IDX_W'(count_clamped - 1'b1);
      bitcnt <= '0;
      shreg  <= value;
      if (func) begin
        digits <= hex_load;
      end else begin
        digits <= '0;
      end
    end else if (cmd.shift) begin
      digits <= {adjusted[BCD_W-2:0], shreg[VALUE_W-1]};
      shreg  <= {shreg[VALUE_W-2:0], 1'b0};
      bitcnt <= bitcnt + 1'b1;
    end else if (cmd.emit) begin
      idx <= idx - 1'b1;
    end
  end

  // Output register, one character per emit step
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      char_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ascii_char <= cur_char;
      last       <= (idx == '0);
    end
  end

endmodule

`default_nettype wire

[hdl/fixed_width_number_to_ascii.sv]
// Top level of the fixed-width number to ASCII converter.
// Instantiates fwna_ctrl and fwna_datapath; depends on fwna_pkg.
//
// Usage:
//   An item (func, value, digit_count) is taken at a rising edge where start
//   is high and busy is low. The block then emits min(digit_count,
//   MAX_DIGITS) characters, most significant first, zero padded. Each
//   character appears on ascii_char for one cycle with char_valid high;
//   last marks the final one. func = 0 gives decimal digits (value modulo
//   10^n), func = 1 gives uppercase hex digits of the low 4n bits.
//   A count of zero produces no characters and busy stays low.
// Timing:
//   Decimal: shift-add-3 conversion of the whole value (one value bit per
//   cycle), then one character per cycle. Hex: no conversion; the emit
//   state follows acceptance directly.
//   The next item may be accepted in the cycle the last character shows.
// Reset: synchronous rst returns to idle and drops char_valid.
// The receiver cannot stall: every character is taken in its cycle.
`default_nettype none

module fixed_width_number_to_ascii
  import fwna_pkg::*;
#(
  parameter int MAX_DIGITS = 20
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [COUNT_W-1:0] digit_count,
  output logic [CHAR_W-1:0]       ascii_char,
  output logic                    last,
  output logic                    char_valid
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  fwna_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  fwna_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .value       (value),
    .digit_count (digit_count),
    .cmd         (cmd),
    .sts         (sts),
    .ascii_char  (ascii_char),
    .last        (last),
    .char_valid  (char_valid)
  );

`ifndef SYNTHESIS
  // Emitted characters are decimal digits or uppercase hex letters
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> ((ascii_char >= 7'd48 && ascii_char <= 7'd57) ||
                    (ascii_char >= 7'd65 && ascii_char <= 7'd70)))
    else $error("character out of range");

  // A nonzero count makes the block busy after acceptance
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && digit_count != '0) |=> busy)
    else $error("busy not raised after accepting an item");

  // Nothing follows the last character in the next cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last) |=> !char_valid)
    else $error("character right after last");
`endif

endmodule

`default_nettype wire
